FILE: src/ptw_pkg.sv
package ptw_pkg;

  localparam int SLOTS    = 64;
  localparam int TASKS    = 16;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int IDX_W    = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int PERIOD_W = 16;
  localparam int ROUND_W  = PERIOD_W - SLOT_W;
  localparam int ID_W     = 4;
  localparam int CMD_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FLUSH = 2'd2
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic tick_start;  // accepted item is a tick
    logic scan_step;   // handle one entry
    logic flush_push;  // move held result to output with last set
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic scan_done;
    logic pend_valid;
  } stat_t;

endpackage

FILE: src/ptw_ctrl.sv
module ptw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  ptw_pkg::cmd_t  in_cmd,
  output logic           in_ready,
  input  ptw_pkg::stat_t stat,
  output ptw_pkg::ctrl_t ctrl
);
  import ptw_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_cmd == CMD_TICK) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.out_free && stat.scan_done) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!stat.pend_valid || stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    ctrl.accept     = 1'b0;
    ctrl.tick_start = 1'b0;
    ctrl.scan_step  = 1'b0;
    ctrl.flush_push = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready        = 1'b1;
        ctrl.accept     = in_valid;
        ctrl.tick_start = in_valid && in_cmd == CMD_TICK;
      end
      ST_SCAN: begin
        // hold the scan while the output register is blocked
        ctrl.scan_step = stat.out_free;
      end
      ST_FLUSH: begin
        ctrl.flush_push = stat.pend_valid && stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/ptw_dp.sv
module ptw_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptw_pkg::cmd_t                 in_cmd,
  input  logic [ptw_pkg::ID_W-1:0]      in_id,
  input  logic [ptw_pkg::PERIOD_W-1:0]  in_period,
  input  ptw_pkg::ctrl_t                ctrl,
  output ptw_pkg::stat_t                stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ptw_pkg::ID_W-1:0]      out_id,
  output logic                          out_last
);
  import ptw_pkg::*;

  logic [TASKS-1:0]    valid_r, valid_nxt;
  logic [SLOT_W-1:0]   slot_r   [TASKS];
  logic [ROUND_W-1:0]  rounds_r [TASKS];
  logic [PERIOD_W-1:0] per_r    [TASKS];

  logic [SLOT_W-1:0]   cur_slot_r, cur_slot_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0]    pend_id_r, pend_id_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic                out_last_r, out_last_nxt;

  logic                id_ok;
  logic [IDX_W-1:0]    id_idx;
  logic                hit, fire, push, out_free;
  logic [SLOT_W-1:0]   e_slot;
  logic [ROUND_W-1:0]  e_rounds;
  logic [PERIOD_W-1:0] e_per;
  logic [PERIOD_W:0]   add_sum, rearm_sum;

  logic                wr_en, wr_per_en;
  logic [IDX_W-1:0]    wr_idx;
  logic [SLOT_W-1:0]   wr_slot;
  logic [ROUND_W-1:0]  wr_rounds;
  logic [PERIOD_W-1:0] wr_per;

  assign id_ok    = int'(in_id) < TASKS;
  assign id_idx   = IDX_W'(in_id);
  assign e_slot   = slot_r[idx_r];
  assign e_rounds = rounds_r[idx_r];
  assign e_per    = per_r[idx_r];
  assign hit      = valid_r[idx_r] && e_slot == cur_slot_r;
  assign fire     = hit && e_rounds == '0;
  assign out_free = !out_valid_r || out_ready;
  assign push     = (ctrl.scan_step && fire && pend_valid_r) || ctrl.flush_push;

  assign add_sum   = {{(PERIOD_W + 1 - SLOT_W){1'b0}}, cur_slot_r} + {1'b0, in_period};
  assign rearm_sum = {{(PERIOD_W + 1 - SLOT_W){1'b0}}, cur_slot_r} + {1'b0, e_per};

  assign stat.out_free   = out_free;
  assign stat.scan_done  = int'(idx_r) == TASKS - 1;
  assign stat.pend_valid = pend_valid_r;

  assign out_valid = out_valid_r;
  assign out_id    = out_id_r;
  assign out_last  = out_last_r;

  // entry table write port: add or delete command, or round countdown and re-arm during the scan
  always_comb begin
    valid_nxt = valid_r;
    wr_en     = 1'b0;
    wr_per_en = 1'b0;
    wr_idx    = idx_r;
    wr_slot   = e_slot;
    wr_rounds = e_rounds;
    wr_per    = in_period;
    if (ctrl.accept && id_ok && in_cmd == CMD_ADD) begin
      wr_en             = 1'b1;
      wr_per_en         = 1'b1;
      wr_idx            = id_idx;
      wr_slot           = SLOT_W'(add_sum % SLOTS);
      wr_rounds         = ROUND_W'(in_period / SLOTS);
      valid_nxt[id_idx] = 1'b1;
    end else if (ctrl.accept && id_ok && in_cmd == CMD_DEL) begin
      valid_nxt[id_idx] = 1'b0;
    end else if (ctrl.scan_step && hit) begin
      wr_en = 1'b1;
      if (!fire) begin
        wr_rounds = e_rounds - 1'b1;
      end else if (e_per == '0) begin
        wr_slot   = SLOT_W'((cur_slot_r + 1'b1) % SLOTS);
        wr_rounds = '0;
      end else begin
        wr_slot   = SLOT_W'(rearm_sum % SLOTS);
        wr_rounds = ROUND_W'(e_per / SLOTS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_idx]   <= wr_slot;
      rounds_r[wr_idx] <= wr_rounds;
    end
    if (wr_per_en) begin
      per_r[wr_idx] <= wr_per;
    end
  end

  always_comb begin
    cur_slot_nxt   = cur_slot_r;
    idx_nxt        = idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    out_valid_nxt  = out_valid_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;

    if (ctrl.tick_start) begin
      idx_nxt        = '0;
      pend_valid_nxt = 1'b0;
    end
    if (ctrl.scan_step) begin
      idx_nxt = idx_r + 1'b1;
      // hold each fired id until the next one fires so the final one can carry last
      if (fire) begin
        pend_valid_nxt = 1'b1;
        pend_id_nxt    = idx_r;
      end
      if (stat.scan_done) begin
        cur_slot_nxt = SLOT_W'((cur_slot_r + 1'b1) % SLOTS);
      end
    end
    if (ctrl.flush_push) begin
      pend_valid_nxt = 1'b0;
    end

    if (push) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = ID_W'(pend_id_r);
      out_last_nxt  = ctrl.flush_push;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      cur_slot_r   <= '0;
      idx_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      cur_slot_r   <= cur_slot_nxt;
      idx_r        <= idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r  <= pend_id_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

FILE: src/periodic_timer_wheel_top.sv
// Hashed timing wheel: 64 slots, up to 16 periodic timers.
// Input stream (in_t*): one command per transfer, tick, add timer or
// delete timer. Add places a timer at slot (current + period) mod 64 with
// period / 64 full turns to wait; delete drops it.
// Output stream (out_t*): one transfer per timer that fires on a tick,
// carrying its id, ascending; out_tlast marks the final one of the tick.
// A tick with no expired timer produces no transfer.
// Add and delete are taken while idle and leave in_tready high. A tick scans
// the entry table one entry per cycle while the output register is free, and
// holds in_tready low through the scan of all 16 entries and the hand-over
// of the final result. A fired id is held back and moves to the output
// register when the next one is found, or in the flush after the scan.
// in_tready is high only between commands; during a tick it stays low.
// If the receiver holds out_tready low, the scan pauses until the output
// register frees; no result is dropped.
// Reset clears all timers, the current slot and the output register;
// the block is ready for commands as soon as reset is released.
module periodic_timer_wheel_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [1:0] command, [5:2] timer_id, [21:6] period_ticks
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [3:0] fired_id
  output logic        out_tlast
);
  import ptw_pkg::*;

  cmd_t                in_cmd;
  logic [ID_W-1:0]     in_id;
  logic [PERIOD_W-1:0] in_period;
  logic [ID_W-1:0]     out_id;
  ctrl_t               ctrl;
  stat_t               stat;

  assign in_cmd    = cmd_t'(in_tdata[1:0]);
  assign in_id     = in_tdata[5:2];
  assign in_period = in_tdata[21:6];
  assign out_tdata = {4'b0, out_id};

  ptw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_cmd),
    .in_ready (in_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  ptw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cmd    (in_cmd),
    .in_id     (in_id),
    .in_period (in_period),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_id    (out_id),
    .out_last  (out_tlast)
  );

endmodule

FILE: dv/ptw_fire_checker.sv
`timescale 1ns / 100ps

module ptw_fire_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [23:0] in_tdata,   // [1:0] command, [5:2] timer_id, [21:6] period_ticks
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,   // [3:0] fired_id
  input  logic       out_tlast,
  output int         fail_cnt,
  output int         pend_cnt,
  output int         fired_cnt
);
  import ptw_pkg::*;

  typedef struct {
    logic [ID_W-1:0] id;
    logic            last;
  } fire_t;

  fire_t               due_q[$];
  logic                arm_valid  [TASKS];
  logic [SLOT_W-1:0]   arm_slot   [TASKS];
  logic [ROUND_W-1:0]  arm_rounds [TASKS];
  logic [PERIOD_W-1:0] arm_period [TASKS];
  logic [SLOT_W-1:0]   wheel_pos;
  int                  fails = 0;
  int                  fired = 0;

  task automatic log_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fails++;
  endtask

  task automatic arm_timer(int idx, logic [PERIOD_W-1:0] per);
    arm_slot[idx]   = wheel_pos + per[SLOT_W-1:0];
    arm_rounds[idx] = per[PERIOD_W-1:SLOT_W];
    arm_period[idx] = per;
    arm_valid[idx]  = 1'b1;
  endtask

  // Handle the current slot in entry order, queue the ids that fire, advance.
  task automatic spin_wheel();
    logic [ID_W-1:0]   hits[$];
    logic [SLOT_W-1:0] here;
    fire_t             f;
    here = wheel_pos;
    for (int i = 0; i < TASKS; i++) begin
      if (arm_valid[i] && arm_slot[i] == here) begin
        if (arm_rounds[i] == '0) begin
          hits.insert(hits.size(), ID_W'(i));
          // zero period lands in the next slot so it fires on every tick
          if (arm_period[i] == '0) arm_slot[i] = here + 1'b1;
          else arm_timer(i, arm_period[i]);
        end else begin
          arm_rounds[i] = arm_rounds[i] - 1'b1;
        end
      end
    end
    for (int k = 0; k < hits.size(); k++) begin
      f.id   = hits[k];
      f.last = (k == hits.size() - 1);
      due_q.insert(due_q.size(), f);
    end
    wheel_pos = here + 1'b1;
  endtask

  always @(posedge clk) begin : watch
    cmd_t              cmd;
    logic [ID_W-1:0]   id;
    logic [PERIOD_W-1:0] per;
    fire_t             want;
    if (!rst_n) begin
      for (int i = 0; i < TASKS; i++) begin
        arm_valid[i]  = 1'b0;
        arm_slot[i]   = '0;
        arm_rounds[i] = '0;
        arm_period[i] = '0;
      end
      wheel_pos = '0;
      due_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        cmd = cmd_t'(in_tdata[CMD_W-1:0]);
        id  = in_tdata[CMD_W +: ID_W];
        per = in_tdata[CMD_W+ID_W +: PERIOD_W];
        case (cmd)
          CMD_TICK: spin_wheel();
          CMD_ADD: begin
            if (int'(id) < TASKS) arm_timer(int'(id), per);
          end
          CMD_DEL: begin
            if (int'(id) < TASKS) arm_valid[id] = 1'b0;
          end
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (due_q.size() == 0) begin
          log_mismatch($sformatf("unexpected transfer, fired_id %0d last %0b",
                                 out_tdata[ID_W-1:0], out_tlast));
        end else begin
          want = due_q.pop_front();
          fired++;
          if (out_tdata[ID_W-1:0] !== want.id)
            log_mismatch($sformatf("fired_id %0d, expected %0d",
                                   out_tdata[ID_W-1:0], want.id));
          if (out_tlast !== want.last)
            log_mismatch($sformatf("last %0b on fired_id %0d, expected %0b",
                                   out_tlast, want.id, want.last));
        end
      end
    end
    fail_cnt  <= fails;
    pend_cnt  <= due_q.size();
    fired_cnt <= fired;
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import ptw_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [23:0] in_tdata = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  int fail_cnt;
  int pend_cnt;
  int fired_cnt;
  int cmds_sent = 0;
  int ticks_sent = 0;
  bit gaps_on = 1'b1;
  int stall_mode = 1;
  int stall_left = 0;
  int stall_now;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  periodic_timer_wheel_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  ptw_fire_checker u_fire_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .fail_cnt  (fail_cnt),
    .pend_cnt  (pend_cnt),
    .fired_cnt (fired_cnt)
  );

  // Mostly short stalls, a few long ones; mode 0 never stalls.
  function automatic int stall_len(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (mode == 1) begin
      if (r < 80) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Short periods fire often, mid ones exercise the round count, some span the full field.
  function automatic logic [PERIOD_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return PERIOD_W'($urandom_range(0, 8));
    if (r < 60) return PERIOD_W'($urandom_range(9, 140));
    if (r < 80) return PERIOD_W'($urandom_range(141, 400));
    return PERIOD_W'($urandom_range(0, 65535));
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall_now = stall_len(stall_mode);
      if (stall_now > 0) begin
        stall_left <= stall_now - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Hold the command until the block takes it.
  task automatic send(cmd_t cmd, logic [ID_W-1:0] id, logic [PERIOD_W-1:0] per);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, per, id, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    cmds_sent++;
    if (cmd == CMD_TICK) ticks_sent++;
  endtask

  // Stop sending until every predicted expiry has been seen, then let the scan finish.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pend_cnt != 0);
    repeat (24) @(posedge clk);
  endtask

  task automatic send_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) send(CMD_TICK, ID_W'($urandom), PERIOD_W'($urandom));
    else if (r < 80) send(CMD_ADD, ID_W'($urandom), pick_period());
    else if (r < 94) send(CMD_DEL, ID_W'($urandom), PERIOD_W'($urandom));
    else send(CMD_NOP, ID_W'($urandom), PERIOD_W'($urandom));
  endtask

  initial begin
    #10_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty wheel, ignored command, delete of an absent timer
    send(CMD_TICK, 4'd0, 16'd0);
    send(CMD_NOP, 4'hf, 16'hffff);
    send(CMD_DEL, 4'd5, 16'd0);
    // every entry on a zero period: a tick fires all of them
    for (int i = 0; i < TASKS; i++) send(CMD_ADD, ID_W'(i), 16'd0);
    send(CMD_TICK, 4'd0, 16'd0);
    send(CMD_ADD, 4'd3, 16'hffff);
    send(CMD_ADD, 4'd7, 16'd64);
    send(CMD_ADD, 4'd9, 16'd1);
    send(CMD_DEL, 4'd0, 16'd0);
    send(CMD_TICK, 4'd0, 16'd0);
    send(CMD_TICK, 4'd0, 16'd0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      gaps_on = (phase != 1);
      stall_mode <= (phase == 1) ? 0 : (phase == 2) ? 2 : 1;
      repeat (60) send_random();
      drain();
    end

    $display("summary: %0d commands sent, %0d of them ticks, %0d expiries checked",
             cmds_sent, ticks_sent, fired_cnt);
    $display("summary: full table firing on one tick, replace, delete, wrap and long periods");
    if (fail_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
